[design/hst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hst_pkg - shared types and constants for the skirted heightfield triangulator
// Vertex and triangle layouts, field widths, register indexes, reset values.
// ----------------------------------------------------------------------------
package hst_pkg;

    localparam int DEFAULT_MAX_GRID = 1024;

    localparam int CoordW   = 10;
    localparam int HeightW  = 16;
    localparam int CfgW     = 11;
    localparam int CfgIdxW  = 1;
    localparam int MaxTri   = 5;
    localparam int TriCntW  = 3;
    localparam int InDataW  = 16;
    localparam int OutDataW = 112;

    localparam logic [CfgW-1:0] CFG_RESET_SIZE = 11'd16;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_GRID_LENGTH = 1'b0,
        CFG_GRID_WIDTH  = 1'b1
    } t_cfg_idx;

    // x in the lowest bits, then y, then z
    typedef struct packed {
        logic [HeightW-1:0] z;
        logic [CoordW-1:0]  y;
        logic [CoordW-1:0]  x;
    } t_vtx;

    // vertex a in the lowest bits
    typedef struct packed {
        t_vtx c;
        t_vtx b;
        t_vtx a;
    } t_tri;

    localparam int TriPadW = OutDataW - $bits(t_tri);

    function automatic t_vtx mk_vtx(input logic [CoordW-1:0] x,
                                    input logic [CoordW-1:0] y,
                                    input logic [HeightW-1:0] z);
        t_vtx v;
        v.x = x;
        v.y = y;
        v.z = z;
        return v;
    endfunction

    function automatic t_tri mk_tri(input t_vtx a, input t_vtx b, input t_vtx c);
        t_tri t;
        t.a = a;
        t.b = b;
        t.c = c;
        return t;
    endfunction

endpackage

[design/hst_line_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hst_line_buf - previous-row height buffer
// One address per cycle, read before write, registered read data.
// ----------------------------------------------------------------------------
module hst_line_buf #(
    parameter int MAX_GRID = hst_pkg::DEFAULT_MAX_GRID
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [$clog2(MAX_GRID)-1:0] i_addr,
    input  logic [hst_pkg::HeightW-1:0] i_wr_data,
    output logic [hst_pkg::HeightW-1:0] o_rd_data
);
    import hst_pkg::*;

    logic [HeightW-1:0] r_mem [MAX_GRID];
    logic [HeightW-1:0] r_rd_data;

    // old entry is read out while the new sample replaces it
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data     <= r_mem[i_addr];
            r_mem[i_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/hst_tri_build.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hst_tri_build - triangle list for one grid sample
// Surface cell pair, edge fans to the bottom corners and the bottom faces,
// packed in emission order with a count.
// ----------------------------------------------------------------------------
module hst_tri_build #(
    parameter int MAX_GRID = hst_pkg::DEFAULT_MAX_GRID
) (
    input  logic [$clog2(MAX_GRID)-1:0]   i_row,
    input  logic [$clog2(MAX_GRID)-1:0]   i_col,
    input  logic [$clog2(MAX_GRID+1)-1:0] i_len,
    input  logic [$clog2(MAX_GRID+1)-1:0] i_wid,
    input  logic [hst_pkg::HeightW-1:0]   i_height,
    input  logic [hst_pkg::HeightW-1:0]   i_prev_height,
    input  logic [hst_pkg::HeightW-1:0]   i_above,
    input  logic [hst_pkg::HeightW-1:0]   i_diag,
    output hst_pkg::t_tri                 o_tri [hst_pkg::MaxTri],
    output logic [hst_pkg::TriCntW-1:0]   o_cnt
);
    import hst_pkg::*;

    localparam int CW = $clog2(MAX_GRID);
    localparam int SW = $clog2(MAX_GRID+1);

    logic [CW-1:0] row_m1, col_m1;
    logic [SW-1:0] len_m1, wid_m1, len_half, wid_half, row_ext, col_ext;
    logic [SW:0]   len_p1, wid_p1;
    logic          row_zero, col_zero, col_lt_half, col_at_half;
    logic          row_lt_half, row_at_half, row_bottom, col_right;
    t_vtx          rf, lf, rb, lb, cur, last_v, p, p1, p2;

    assign row_m1   = i_row - 1'b1;
    assign col_m1   = i_col - 1'b1;
    assign len_m1   = i_len - 1'b1;
    assign wid_m1   = i_wid - 1'b1;
    assign len_p1   = {1'b0, i_len} + 1'b1;
    assign wid_p1   = {1'b0, i_wid} + 1'b1;
    assign len_half = SW'(len_p1 >> 1);
    assign wid_half = SW'(wid_p1 >> 1);
    assign row_ext  = SW'(i_row);
    assign col_ext  = SW'(i_col);

    assign row_zero    = (i_row == '0);
    assign col_zero    = (i_col == '0);
    assign col_lt_half = (col_ext < wid_half);
    assign col_at_half = (col_ext == wid_half);
    assign row_lt_half = (row_ext < len_half);
    assign row_at_half = (row_ext == len_half);
    assign row_bottom  = (row_ext == len_m1);
    assign col_right   = (col_ext == wid_m1);

    // bottom corners at z = 0
    assign rf  = mk_vtx('0, '0, '0);
    assign lf  = mk_vtx('0, CoordW'(wid_m1), '0);
    assign rb  = mk_vtx(CoordW'(len_m1), '0, '0);
    assign lb  = mk_vtx(CoordW'(len_m1), CoordW'(wid_m1), '0);
    assign cur = mk_vtx(CoordW'(i_row), CoordW'(i_col), i_height);
    assign p   = mk_vtx(CoordW'(row_m1), '0, i_above);
    assign p1  = mk_vtx(CoordW'(row_m1), CoordW'(col_m1), i_diag);
    assign p2  = mk_vtx(CoordW'(row_m1), CoordW'(i_col), i_above);
    // previous sample wraps to the end of the row above at column zero
    assign last_v = col_zero ? mk_vtx(CoordW'(row_m1), CoordW'(wid_m1), i_prev_height)
                             : mk_vtx(CoordW'(i_row), CoordW'(col_m1), i_prev_height);

    always_comb begin
        t_tri              tri_q [MaxTri];
        logic [TriCntW-1:0] n;
        for (int k = 0; k < MaxTri; k++) begin
            tri_q[k] = '0;
        end
        n = '0;
        if (row_zero) begin
            if (col_zero) begin
                // the two bottom faces
                tri_q[n] = mk_tri(rf, lf, lb);
                n = n + 1'b1;
                tri_q[n] = mk_tri(rf, lb, rb);
                n = n + 1'b1;
            end else begin
                tri_q[n] = mk_tri(col_lt_half ? rf : lf, last_v, cur);
                n = n + 1'b1;
                if (col_at_half) begin
                    tri_q[n] = mk_tri(rf, last_v, lf);
                    n = n + 1'b1;
                end
            end
        end else if (col_zero) begin
            tri_q[n] = mk_tri(p, row_lt_half ? rf : rb, cur);
            n = n + 1'b1;
            if (row_at_half) begin
                tri_q[n] = mk_tri(lb, lf, last_v);
                n = n + 1'b1;
                tri_q[n] = mk_tri(rb, p, rf);
                n = n + 1'b1;
            end
        end else begin
            tri_q[n] = mk_tri(p1, last_v, cur);
            n = n + 1'b1;
            tri_q[n] = mk_tri(p2, p1, cur);
            n = n + 1'b1;
            if (row_bottom) begin
                tri_q[n] = mk_tri(last_v, col_lt_half ? rb : lb, cur);
                n = n + 1'b1;
                if (col_at_half) begin
                    tri_q[n] = mk_tri(rb, lb, last_v);
                    n = n + 1'b1;
                end
            end
            if (col_right) begin
                tri_q[n] = mk_tri(row_lt_half ? lf : lb, p2, cur);
                n = n + 1'b1;
            end
        end
        o_tri = tri_q;
        o_cnt = n;
    end

endmodule

[design/heightfield_skirted_triangulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_skirted_triangulator - closes a height grid into a solid
// Raster-order height samples in, surface, skirt and bottom triangles out.
//
//   channel   | direction | contents
//   s_axis    | in        | tdata[15:0] height
//   m_axis    | out       | tdata a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z; tlast run_end
//   cfg write | in        | index 0 grid_length, index 1 grid_width
//
// A sample enters an input stage that reads the line buffer, then the
// triangle list register, which drains one triangle per cycle while the output is ready.
// Each sample causes one to five triangles; the output drain is the limit.
// A transferred sample passes the input stage and then the list register to the output.
// Reset clears the counters and held heights, not the line buffer.
// A stalled output holds the list and the input stage until the list can reload.
// ----------------------------------------------------------------------------
module heightfield_skirted_triangulator #(
    parameter int MAX_GRID = hst_pkg::DEFAULT_MAX_GRID
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hst_pkg::InDataW-1:0]   s_axis_tdata,   // height
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero pad
    output logic [hst_pkg::OutDataW-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast,   // run_end
    input  logic                          i_cfg_wr_en,
    input  logic [hst_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [hst_pkg::CfgW-1:0]      i_cfg_wr_data
);
    import hst_pkg::*;

    localparam int CW = $clog2(MAX_GRID);
    localparam int SW = $clog2(MAX_GRID+1);

    logic [CfgW-1:0]    r_cfg_len, r_cfg_wid;
    logic [SW-1:0]      len_c, wid_c;
    logic [CW-1:0]      r_row, r_col, n_row, n_col;
    logic [SW-1:0]      col_inc, row_inc;
    logic [HeightW-1:0] r_prev_h, r_diag;

    logic               r_s1_valid;
    logic [CW-1:0]      r_s1_row, r_s1_col;
    logic [HeightW-1:0] r_s1_h, r_s1_prev;
    logic [HeightW-1:0] above;

    logic               r_lst_valid;
    t_tri               r_lst_tri [MaxTri];
    logic [TriCntW-1:0] r_lst_cnt, r_lst_idx;

    t_tri               bld_tri [MaxTri];
    logic [TriCntW-1:0] bld_cnt;

    logic in_xfer, out_xfer, out_last, lst_free, s1_move;

    // size clamp to 2..MAX_GRID
    function automatic logic [SW-1:0] clamp_size(input logic [CfgW-1:0] v);
        if (v < CfgW'(2)) begin
            return SW'(2);
        end else if (32'(v) > 32'(MAX_GRID)) begin
            return SW'(MAX_GRID);
        end else begin
            return SW'(v);
        end
    endfunction

    assign len_c = clamp_size(r_cfg_len);
    assign wid_c = clamp_size(r_cfg_wid);

    // handshakes
    assign out_last      = (r_lst_idx == r_lst_cnt - 1'b1);
    assign out_xfer      = m_axis_tvalid & m_axis_tready;
    assign lst_free      = ~r_lst_valid | (out_xfer & out_last);
    assign s1_move       = r_s1_valid & lst_free;
    assign s_axis_tready = ~r_s1_valid | s1_move;
    assign in_xfer       = s_axis_tvalid & s_axis_tready;

    assign m_axis_tvalid = r_lst_valid;
    assign m_axis_tdata  = {{TriPadW{1'b0}}, r_lst_tri[r_lst_idx]};
    assign m_axis_tlast  = out_last;

    // raster position advance
    assign col_inc = SW'(r_col) + 1'b1;
    assign row_inc = SW'(r_row) + 1'b1;
    always_comb begin
        if (col_inc >= wid_c) begin
            n_col = '0;
            n_row = (row_inc >= len_c) ? '0 : CW'(row_inc);
        end else begin
            n_col = CW'(col_inc);
            n_row = r_row;
        end
    end

    hst_line_buf #(
        .MAX_GRID (MAX_GRID)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_en      (in_xfer),
        .i_addr    (r_col),
        .i_wr_data (s_axis_tdata),
        .o_rd_data (above)
    );

    hst_tri_build #(
        .MAX_GRID (MAX_GRID)
    ) u_tri_build (
        .i_row         (r_s1_row),
        .i_col         (r_s1_col),
        .i_len         (len_c),
        .i_wid         (wid_c),
        .i_height      (r_s1_h),
        .i_prev_height (r_s1_prev),
        .i_above       (above),
        .i_diag        (r_diag),
        .o_tri         (bld_tri),
        .o_cnt         (bld_cnt)
    );

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len   <= CFG_RESET_SIZE;
            r_cfg_wid   <= CFG_RESET_SIZE;
            r_row       <= '0;
            r_col       <= '0;
            r_prev_h    <= '0;
            r_diag      <= '0;
            r_s1_valid  <= 1'b0;
            r_lst_valid <= 1'b0;
            r_lst_idx   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_GRID_LENGTH: r_cfg_len <= i_cfg_wr_data;
                    CFG_GRID_WIDTH:  r_cfg_wid <= i_cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            if (in_xfer) begin
                r_row    <= n_row;
                r_col    <= n_col;
                r_prev_h <= s_axis_tdata;
            end
            if (s1_move) begin
                r_diag <= above;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_lst_valid <= 1'b1;
                r_lst_idx   <= '0;
            end else if (out_xfer && out_last) begin
                r_lst_valid <= 1'b0;
            end else if (out_xfer) begin
                r_lst_idx <= r_lst_idx + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
            r_s1_h    <= s_axis_tdata;
            r_s1_prev <= r_prev_h;
        end
        if (s1_move) begin
            r_lst_tri <= bld_tri;
            r_lst_cnt <= bld_cnt;
        end
    end

endmodule
